// ===== hdl/brs_pkg.sv =====
// Shared widths, limits and register indexes of the bilinear plane resizer.
package brs_pkg;

    localparam int MAX_SRC_DIM = 256;
    localparam int MAX_DST_DIM = 1024;

    localparam int SRC_DIM_W   = $clog2(MAX_SRC_DIM + 1);
    localparam int SRC_IDX_W   = $clog2(MAX_SRC_DIM);
    localparam int DST_DIM_W   = $clog2(MAX_DST_DIM + 1);
    localparam int DST_IDX_W   = $clog2(MAX_DST_DIM);
    localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int AREA_W      = ADDR_W + 1;

    localparam int SAMPLE_W    = 8;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = 24;
    localparam int PIXEL_W     = 16;
    localparam int TOP_W       = SAMPLE_W + FRAC_W;
    localparam int ACC_W       = SAMPLE_W + 2 * FRAC_W;
    localparam int MUL_W       = STEP_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int POS_W       = DST_IDX_W + STEP_W;
    localparam int LOC_W       = SRC_IDX_W + FRAC_W;

    localparam int CFG_SRC_W   = 9;
    localparam int CFG_DST_W   = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_X_STEP     = 3'd4,
        CFG_Y_STEP     = 3'd5
    } t_cfg_index;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

endpackage

// ===== hdl/bilinear_plane_resize_top.sv =====
// Bilinear plane resizer: frame store, sequencer and one shared multiplier.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------
//  in      | i_in_valid / o_in_ready  | i_mode, i_sample
//  cfg     | i_cfg_we                 | i_cfg_index, i_cfg_data
//  out     | o_out_valid / i_out_ready| o_pixel_value, o_frame_last
//
// A load request writes one sample; an emit request waits in FIN while the
// output register still holds an untaken pixel. The 25x25 multiplier is
// used seven times per pixel and the frame store read port four times.
// Reset is synchronous, active low; the frame store itself is not cleared.
// A waiting output does not block loads or the start of the next emit.
module bilinear_plane_resize_top
    import brs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_mode,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIXEL_W-1:0]    o_pixel_value,
    output logic                  o_frame_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_LD, S_MX, S_MY, S_YS, S_B0, S_B1, S_R0,
        S_R1, S_R2, S_R3, S_M0, S_M1, S_M2, S_M3, S_FIN
    } t_state;

    t_state r_state;

    logic [CFG_SRC_W-1:0] r_src_width, r_src_height;
    logic [CFG_DST_W-1:0] r_dst_width, r_dst_height;
    logic [STEP_W-1:0]    r_x_step, r_y_step;

    logic [ADDR_W-1:0]    r_ld_addr;
    logic [DST_IDX_W-1:0] r_dcol, r_drow;
    logic [DST_IDX_W-1:0] r_col, r_row;
    logic                 r_last;
    logic [SAMPLE_W-1:0]  r_sample;

    logic [SRC_IDX_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic [FRAC_W-1:0]    r_dx, r_dy;
    logic [ADDR_W-1:0]    r_base0, r_base1;
    logic [SAMPLE_W-1:0]  r_a, r_b, r_c, r_d;
    logic [TOP_W-1:0]     r_top, r_bot;

    logic signed [PROD_W-1:0] r_prod;
    logic [SAMPLE_W-1:0]      r_rdata;
    logic [SAMPLE_W-1:0]      mem [STORE_DEPTH];

    logic                 r_out_valid;
    logic [PIXEL_W-1:0]   r_pixel;
    logic                 r_frame_last;

    logic [SRC_DIM_W-1:0] sw, sh;
    logic [DST_DIM_W-1:0] dw, dh;

    // clamp dimensions into their legal range
    always_comb begin
        if (r_src_width == '0) begin
            sw = SRC_DIM_W'(1);
        end else if (32'(r_src_width) > MAX_SRC_DIM) begin
            sw = SRC_DIM_W'(MAX_SRC_DIM);
        end else begin
            sw = SRC_DIM_W'(r_src_width);
        end
        if (r_src_height == '0) begin
            sh = SRC_DIM_W'(1);
        end else if (32'(r_src_height) > MAX_SRC_DIM) begin
            sh = SRC_DIM_W'(MAX_SRC_DIM);
        end else begin
            sh = SRC_DIM_W'(r_src_height);
        end
        if (r_dst_width == '0) begin
            dw = DST_DIM_W'(1);
        end else if (32'(r_dst_width) > MAX_DST_DIM) begin
            dw = DST_DIM_W'(MAX_DST_DIM);
        end else begin
            dw = DST_DIM_W'(r_dst_width);
        end
        if (r_dst_height == '0) begin
            dh = DST_DIM_W'(1);
        end else if (32'(r_dst_height) > MAX_DST_DIM) begin
            dh = DST_DIM_W'(MAX_DST_DIM);
        end else begin
            dh = DST_DIM_W'(r_dst_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= CFG_SRC_W'(1);
            r_src_height <= CFG_SRC_W'(1);
            r_dst_width  <= CFG_DST_W'(1);
            r_dst_height <= CFG_DST_W'(1);
            r_x_step     <= '0;
            r_y_step     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[CFG_SRC_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[CFG_SRC_W-1:0];
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[CFG_DST_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[CFG_DST_W-1:0];
                CFG_X_STEP:     r_x_step     <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP:     r_y_step     <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand selection
    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [SAMPLE_W:0]    diff_ba, diff_dc;
    logic signed [TOP_W:0]       diff_bt;

    assign diff_ba = $signed({1'b0, r_b}) - $signed({1'b0, r_a});
    assign diff_dc = $signed({1'b0, r_d}) - $signed({1'b0, r_c});
    assign diff_bt = $signed({1'b0, r_bot}) - $signed({1'b0, r_top});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE: begin
                mul_a = MUL_W'(sw);
                mul_b = MUL_W'(sh);
            end
            S_MX: begin
                mul_a = MUL_W'(r_col);
                mul_b = MUL_W'(r_x_step);
            end
            S_MY: begin
                mul_a = MUL_W'(r_row);
                mul_b = MUL_W'(r_y_step);
            end
            S_B0: begin
                mul_a = MUL_W'(r_y0);
                mul_b = MUL_W'(sw);
            end
            S_B1: begin
                mul_a = MUL_W'(r_y1);
                mul_b = MUL_W'(sw);
            end
            S_M0: begin
                mul_a = MUL_W'(diff_ba);
                mul_b = MUL_W'(r_dx);
            end
            S_M1: begin
                mul_a = MUL_W'(diff_dc);
                mul_b = MUL_W'(r_dx);
            end
            S_M3: begin
                mul_a = MUL_W'(diff_bt);
                mul_b = MUL_W'(r_dy);
            end
            default: ;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // split a Q8.16 position into two neighbours and a fraction
    logic [SRC_DIM_W-1:0]        loc_size;
    logic [POS_W-1:0]            loc_raw;
    logic [SRC_DIM_W+FRAC_W-1:0] loc_lim;
    logic [LOC_W-1:0]            loc_pos;
    logic [SRC_IDX_W-1:0]        loc_i0, loc_i1;
    logic [SRC_DIM_W-1:0]        loc_i0p;

    always_comb begin
        loc_size = (r_state == S_MY) ? sw : sh;
        loc_raw  = r_prod[POS_W-1:0];
        loc_lim  = {loc_size - SRC_DIM_W'(1), FRAC_W'(0)};
        loc_pos  = (loc_raw > POS_W'(loc_lim)) ? LOC_W'(loc_lim) : LOC_W'(loc_raw);
        loc_i0   = loc_pos[LOC_W-1:FRAC_W];
        loc_i0p  = SRC_DIM_W'(loc_i0) + SRC_DIM_W'(1);
        loc_i1   = (loc_i0p < loc_size) ? loc_i0p[SRC_IDX_W-1:0]
                                        : SRC_IDX_W'(loc_size - SRC_DIM_W'(1));
    end

    // destination counters
    logic [DST_IDX_W-1:0] col_n, row_n;
    logic [DST_DIM_W-1:0] col_inc, row_inc;
    logic                 last_n;

    always_comb begin
        col_n   = (DST_DIM_W'(r_dcol) >= dw) ? '0 : r_dcol;
        row_n   = (DST_DIM_W'(r_drow) >= dh) ? '0 : r_drow;
        last_n  = (DST_DIM_W'(col_n) == dw - DST_DIM_W'(1)) &&
                  (DST_DIM_W'(row_n) == dh - DST_DIM_W'(1));
        col_inc = DST_DIM_W'(col_n) + DST_DIM_W'(1);
        row_inc = DST_DIM_W'(row_n) + DST_DIM_W'(1);
    end

    // load address
    logic [AREA_W-1:0] area;
    logic [ADDR_W-1:0] ld_addr;
    logic [AREA_W-1:0] ld_inc;

    always_comb begin
        area    = r_prod[AREA_W-1:0];
        ld_addr = (AREA_W'(r_ld_addr) >= area) ? '0 : r_ld_addr;
        ld_inc  = AREA_W'(ld_addr) + AREA_W'(1);
    end

    logic [ADDR_W-1:0] rd_addr;

    always_comb begin
        case (r_state)
            S_R0:    rd_addr = r_base0 + ADDR_W'(r_x0);
            S_R1:    rd_addr = r_base0 + ADDR_W'(r_x1);
            S_R2:    rd_addr = r_base1 + ADDR_W'(r_x0);
            S_R3:    rd_addr = r_base1 + ADDR_W'(r_x1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LD) begin
            mem[ld_addr] <= r_sample;
        end
        r_rdata <= mem[rd_addr];
    end

    logic [ACC_W-1:0] acc;
    logic             out_free;
    logic             in_acc;

    assign acc      = {r_top, FRAC_W'(0)} + r_prod[ACC_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ld_addr   <= '0;
            r_dcol      <= '0;
            r_drow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state != S_FIN) begin
                r_prod <= mul_p;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sample <= i_sample;
                        if (i_mode == MODE_LOAD) begin
                            r_state <= S_LD;
                        end else begin
                            r_col  <= col_n;
                            r_row  <= row_n;
                            r_last <= last_n;
                            if (col_inc >= dw) begin
                                r_dcol <= '0;
                                r_drow <= (row_inc >= dh) ? '0 : row_inc[DST_IDX_W-1:0];
                            end else begin
                                r_dcol <= col_inc[DST_IDX_W-1:0];
                            end
                            r_state <= S_MX;
                        end
                    end
                end
                S_LD: begin
                    r_ld_addr <= (ld_inc >= area) ? '0 : ld_inc[ADDR_W-1:0];
                    r_state   <= S_IDLE;
                end
                S_MX: r_state <= S_MY;
                S_MY: begin
                    r_x0    <= loc_i0;
                    r_x1    <= loc_i1;
                    r_dx    <= loc_pos[FRAC_W-1:0];
                    r_state <= S_YS;
                end
                S_YS: begin
                    r_y0    <= loc_i0;
                    r_y1    <= loc_i1;
                    r_dy    <= loc_pos[FRAC_W-1:0];
                    r_state <= S_B0;
                end
                S_B0: r_state <= S_B1;
                S_B1: begin
                    r_base0 <= r_prod[ADDR_W-1:0];
                    r_state <= S_R0;
                end
                S_R0: begin
                    r_base1 <= r_prod[ADDR_W-1:0];
                    r_state <= S_R1;
                end
                S_R1: begin
                    r_a     <= r_rdata;
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_b     <= r_rdata;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_c     <= r_rdata;
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_d     <= r_rdata;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_top   <= {r_a, FRAC_W'(0)} + r_prod[TOP_W-1:0];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_bot   <= {r_c, FRAC_W'(0)} + r_prod[TOP_W-1:0];
                    r_state <= S_M3;
                end
                S_M3: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_pixel      <= acc[ACC_W-1:ACC_W-PIXEL_W];
                        r_frame_last <= r_last;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pixel;
    assign o_frame_last  = r_frame_last;

endmodule

// ===== hdl/brs_checker.sv =====
// Port-level checks of the bilinear plane resizer and their binding.
module brs_checker
    import brs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_mode,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [PIXEL_W-1:0] o_pixel_value,
    input logic               o_frame_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pixel_value) && $stable(o_frame_last))
        else $error("output request changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted request");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_LOAD) |=> !$rose(o_out_valid))
        else $error("load request produced a result");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a request in progress");

endmodule

bind bilinear_plane_resize_top brs_checker u_brs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_mode        (i_mode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_value (o_pixel_value),
    .o_frame_last  (o_frame_last)
);
